// ===== hw/rtl/ultrasonic_echo_ranger_assert.svh =====
// Assertion macros used by the ultrasonic echo ranger checker.
`ifndef ULTRASONIC_ECHO_RANGER_ASSERT_SVH
`define ULTRASONIC_ECHO_RANGER_ASSERT_SVH

// Check that cons holds on every edge at which ante holds.
`define UER_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ultrasonic echo ranger: implication check failed");

// Check that cond never holds.
`define UER_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("ultrasonic echo ranger: forbidden condition seen");

`endif

// ===== hw/rtl/uer_pkg.sv =====
// Types, codes and constants of the ultrasonic echo ranger.
package uer_pkg;

  localparam int unsigned CNT_W  = 20;
  localparam int unsigned DIST_W = 15;
  localparam int unsigned TW_W   = 8;
  localparam int unsigned CODE_W = 2;
  localparam int unsigned PH_W   = 3;
  localparam int unsigned REM_W  = 22;
  localparam int unsigned ADDR_W = 4;
  localparam int unsigned DATA_W = 32;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  // Echo width in ticks times this, over the round-trip divisor, gives cm.
  localparam logic [REM_W-1:0] SOUND_CM_PER_S = REM_W'(34029);
  localparam logic [REM_W-1:0] ROUND_TRIP_DIV = REM_W'(2000000);

  // Frame phases.
  localparam logic [PH_W-1:0] PH_IDLE       = 3'd0;
  localparam logic [PH_W-1:0] PH_TRIG       = 3'd1;
  localparam logic [PH_W-1:0] PH_WAIT_START = 3'd2;
  localparam logic [PH_W-1:0] PH_MEASURE    = 3'd3;
  localparam logic [PH_W-1:0] PH_WAIT_NEXT  = 3'd4;

  // Timeout codes.
  localparam logic [CODE_W-1:0] TO_NONE  = 2'd0;
  localparam logic [CODE_W-1:0] TO_START = 2'd1;
  localparam logic [CODE_W-1:0] TO_END   = 2'd2;

  // Register byte addresses.
  localparam logic [ADDR_W-1:0] ADDR_ECHO_LEVEL = 4'h0;
  localparam logic [ADDR_W-1:0] ADDR_PERIOD     = 4'h4;
  localparam logic [ADDR_W-1:0] ADDR_TRIG_WIDTH = 4'h8;

  // Reset values of the registers.
  localparam logic              RST_ECHO_LEVEL = 1'b1;
  localparam logic [CNT_W-1:0]  RST_PERIOD     = CNT_W'(25000);
  localparam logic [TW_W-1:0]   RST_TRIG_WIDTH = TW_W'(20);

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_MAX) ? CNT_MAX : v + CNT_W'(1);
  endfunction

endpackage

// ===== hw/rtl/ultrasonic_echo_ranger.sv =====
// Ultrasonic time-of-flight ranger: trigger, echo timing and distance per tick.
// Throughput: one tick per cycle while the result channel is not stalled; each
// tick passes through the input register, then the result register.
// The echo distance is kept as a running quotient and remainder, so no
// multiplier or divider sits in the path. Reset clears the frame state to idle
// and loads the register defaults: active level 1, period 25000, trigger 20.
module ultrasonic_echo_ranger
  import uer_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // tick input channel
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                echo_level_i,
  input  logic                run_i,
  // result channel
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic                trigger_out_o,
  output logic [DIST_W-1:0]   distance_cm_o,
  output logic                new_distance_o,
  output logic [CODE_W-1:0]   timeout_code_o,
  output logic                running_o,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic             echo_lvl_q;
  logic [CNT_W-1:0] period_q;
  logic [TW_W-1:0]  trig_w_q;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      echo_lvl_q <= RST_ECHO_LEVEL;
      period_q   <= RST_PERIOD;
      trig_w_q   <= RST_TRIG_WIDTH;
    end else if (cfg_wr) begin
      unique case (paddr)
        ADDR_ECHO_LEVEL: echo_lvl_q <= pwdata[0];
        ADDR_PERIOD:     period_q   <= pwdata[CNT_W-1:0];
        ADDR_TRIG_WIDTH: trig_w_q   <= pwdata[TW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      ADDR_ECHO_LEVEL: prdata = {{(DATA_W-1){1'b0}}, echo_lvl_q};
      ADDR_PERIOD:     prdata = {{(DATA_W-CNT_W){1'b0}}, period_q};
      ADDR_TRIG_WIDTH: prdata = {{(DATA_W-TW_W){1'b0}}, trig_w_q};
      default:         prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input register: holds one tick until the result register can take it
  // ---------------------------------------------------------------------------
  logic in_full_q, echo_q, run_q;
  logic out_full_q;
  logic in_xfer, advance;

  // Advance the held tick whenever the result register is empty or draining.
  assign advance    = in_full_q & (~out_full_q | ~out_stall_i);
  assign in_stall_o = in_full_q & ~advance;
  assign in_xfer    = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q <= 1'b0;
    end else begin
      in_full_q <= in_xfer | (in_full_q & ~advance);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      echo_q <= echo_level_i;
      run_q  <= run_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Frame state
  // ---------------------------------------------------------------------------
  logic [PH_W-1:0]   phase_q, phase_d;
  logic [CNT_W-1:0]  frame_q, frame_d;
  logic [CNT_W-1:0]  pticks_q, pticks_d;
  logic [DIST_W-1:0] dist_q, dist_d;
  // Running quotient and remainder of SOUND_CM_PER_S * pticks / ROUND_TRIP_DIV.
  logic [DIST_W-1:0] quo_q, quo_d;
  logic [REM_W-1:0]  rem_q, rem_d;

  logic              trig_d, fresh_d, busy_d;
  logic [CODE_W-1:0] tcode_d;

  logic              active, start, echo_hit;
  logic [PH_W-1:0]   ph_cur;
  logic [CNT_W-1:0]  pt_inc;
  logic [REM_W-1:0]  rem_sum;

  assign echo_hit = (echo_q == echo_lvl_q);
  assign pt_inc   = sat_inc(pticks_q);
  assign rem_sum  = rem_q + SOUND_CM_PER_S;
  assign active   = (phase_q == PH_TRIG) || (phase_q == PH_WAIT_START) ||
                    (phase_q == PH_MEASURE) || (phase_q == PH_WAIT_NEXT);
  // Unused codes fold into idle.
  assign ph_cur   = active ? phase_q : PH_IDLE;

  always_comb begin
    phase_d  = ph_cur;
    frame_d  = active ? sat_inc(frame_q) : frame_q;
    pticks_d = pticks_q;
    dist_d   = dist_q;
    quo_d    = quo_q;
    rem_d    = rem_q;
    trig_d   = 1'b0;
    fresh_d  = 1'b0;
    tcode_d  = TO_NONE;
    busy_d   = active;
    start    = 1'b0;

    unique case (ph_cur)
      PH_TRIG: begin
        trig_d = 1'b1;
        if (pt_inc >= {{(CNT_W-TW_W){1'b0}}, trig_w_q}) begin
          phase_d  = PH_WAIT_START;
          pticks_d = '0;
        end else begin
          pticks_d = pt_inc;
        end
      end
      PH_WAIT_START: begin
        if (echo_hit) begin
          // First active tick counts as one.
          phase_d  = PH_MEASURE;
          pticks_d = CNT_W'(1);
          quo_d    = '0;
          rem_d    = SOUND_CM_PER_S;
        end else if (pt_inc >= period_q) begin
          tcode_d  = TO_START;
          phase_d  = PH_WAIT_NEXT;
          pticks_d = '0;
        end else begin
          pticks_d = pt_inc;
        end
      end
      PH_MEASURE: begin
        if (echo_hit) begin
          if (rem_sum >= ROUND_TRIP_DIV) begin
            rem_d = rem_sum - ROUND_TRIP_DIV;
            quo_d = quo_q + DIST_W'(1);
          end else begin
            rem_d = rem_sum;
          end
          if (pt_inc >= period_q) begin
            tcode_d  = TO_END;
            phase_d  = PH_WAIT_NEXT;
            pticks_d = '0;
          end else begin
            pticks_d = pt_inc;
          end
        end else begin
          // Echo ended: store the distance for the counted width.
          dist_d   = quo_q;
          fresh_d  = 1'b1;
          phase_d  = PH_WAIT_NEXT;
          pticks_d = '0;
        end
      end
      PH_WAIT_NEXT: begin
        if (frame_d >= period_q) begin
          busy_d = 1'b0;
          if (run_q) begin
            start = 1'b1;
          end else begin
            phase_d  = PH_IDLE;
            pticks_d = '0;
            frame_d  = '0;
          end
        end
      end
      default: begin
        start = run_q;
      end
    endcase

    // Frame start: this tick is frame tick 0 and the first trigger tick.
    if (start) begin
      frame_d = '0;
      busy_d  = 1'b1;
      trig_d  = 1'b1;
      if (trig_w_q <= TW_W'(1)) begin
        phase_d  = PH_WAIT_START;
        pticks_d = '0;
      end else begin
        phase_d  = PH_TRIG;
        pticks_d = CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      frame_q  <= '0;
      pticks_q <= '0;
      dist_q   <= '0;
      quo_q    <= '0;
      rem_q    <= '0;
    end else if (advance) begin
      phase_q  <= phase_d;
      frame_q  <= frame_d;
      pticks_q <= pticks_d;
      dist_q   <= dist_d;
      quo_q    <= quo_d;
      rem_q    <= rem_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register: hold while stalled, load on each advance
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_full_q <= 1'b0;
    end else begin
      out_full_q <= advance | (out_full_q & out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      trigger_out_o  <= trig_d;
      distance_cm_o  <= dist_d;
      new_distance_o <= fresh_d;
      timeout_code_o <= tcode_d;
      running_o      <= busy_d;
    end
  end

  assign out_valid_o = out_full_q;

endmodule

// ===== hw/rtl/uer_checker.sv =====
// Port-level checker for the ultrasonic echo ranger, with its bind.
`include "ultrasonic_echo_ranger_assert.svh"

module uer_checker
  import uer_pkg::*;
(
  input logic               clk_i,
  input logic               rst_ni,
  input logic               out_valid_i,
  input logic               out_stall_i,
  input logic               trigger_out_i,
  input logic               new_distance_i,
  input logic [CODE_W-1:0]  timeout_code_i,
  input logic               running_i
);

  logic out_xfer;
  assign out_xfer = out_valid_i & ~out_stall_i;

  `UER_ASSERT_IMPLIES(a_trig_in_frame, clk_i, rst_ni, out_xfer && trigger_out_i, running_i)
  `UER_ASSERT_IMPLIES(a_fresh_in_frame, clk_i, rst_ni, out_xfer && new_distance_i, running_i)
  `UER_ASSERT_IMPLIES(a_fresh_no_timeout, clk_i, rst_ni, out_xfer && new_distance_i, timeout_code_i == TO_NONE)
  `UER_ASSERT_NEVER(a_code_legal, clk_i, rst_ni, out_valid_i && timeout_code_i != TO_NONE && timeout_code_i != TO_START && timeout_code_i != TO_END)

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .trigger_out_i  (trigger_out_o),
  .new_distance_i (new_distance_o),
  .timeout_code_i (timeout_code_o),
  .running_i      (running_o)
);

// ===== tb/tb_ultrasonic_echo_ranger.sv =====
// Self-checking testbench for the ultrasonic echo ranger with a tick-by-tick predictor.
module tb_ultrasonic_echo_ranger;
  import uer_pkg::*;

  // Echo width in ticks times this, over the divisor, gives centimeters.
  localparam longint unsigned ECHO_CM_NUM = 34029;
  localparam longint unsigned ECHO_CM_DEN = 2000000;
  // Result register plus input register, with some slack on top.
  localparam int unsigned SETTLE_CYCLES = 4;
  localparam int unsigned TIMEOUT_CYCLES = 300000;

  typedef struct packed {
    logic echo;
    logic run;
  } echo_tick_t;

  typedef struct packed {
    logic              trigger;
    logic [DIST_W-1:0] distance;
    logic              fresh;
    logic [CODE_W-1:0] code;
    logic              running;
  } ranger_reading_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_COMB
  } stall_mode_e;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_stall_o;
  logic              echo_level_i = 1'b0;
  logic              run_i = 1'b0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  logic              trigger_out_o;
  logic [DIST_W-1:0] distance_cm_o;
  logic              new_distance_o;
  logic [CODE_W-1:0] timeout_code_o;
  logic              running_o;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  ultrasonic_echo_ranger u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .echo_level_i   (echo_level_i),
    .run_i          (run_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .trigger_out_o  (trigger_out_o),
    .distance_cm_o  (distance_cm_o),
    .new_distance_o (new_distance_o),
    .timeout_code_o (timeout_code_o),
    .running_o      (running_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Ranger predictor: its own copy of the configuration and the frame state.
  // ---------------------------------------------------------------------------
  logic              cfg_level  = RST_ECHO_LEVEL;
  logic [CNT_W-1:0]  cfg_period = RST_PERIOD;
  logic [TW_W-1:0]   cfg_trig   = RST_TRIG_WIDTH;

  logic [PH_W-1:0]   frame_phase = PH_IDLE;
  logic [CNT_W-1:0]  frame_cnt   = '0;
  logic [CNT_W-1:0]  phase_cnt   = '0;
  logic [DIST_W-1:0] dist_hold   = '0;

  // Counters stick at all ones instead of wrapping.
  function automatic logic [CNT_W-1:0] count_up(input logic [CNT_W-1:0] v);
    return v + CNT_W'(v != CNT_MAX);
  endfunction

  // Advance the frame by one tick and return the reading it produces.
  task automatic step_ranger(input logic echo, input logic run, output ranger_reading_t rd);
    logic            start;
    longint unsigned prod;
    rd = '0;
    start = 1'b0;
    if (frame_phase == PH_TRIG || frame_phase == PH_WAIT_START ||
        frame_phase == PH_MEASURE || frame_phase == PH_WAIT_NEXT) begin
      frame_cnt = count_up(frame_cnt);
      rd.running = 1'b1;
    end else begin
      // Unused phase codes fall back to idle.
      frame_phase = PH_IDLE;
    end

    case (frame_phase)
      PH_TRIG: begin
        rd.trigger = 1'b1;
        phase_cnt = count_up(phase_cnt);
        if (phase_cnt >= CNT_W'(cfg_trig)) begin
          frame_phase = PH_WAIT_START;
          phase_cnt = '0;
        end
      end
      PH_WAIT_START: begin
        if (echo == cfg_level) begin
          // The tick that first sees the active level counts as one.
          frame_phase = PH_MEASURE;
          phase_cnt = CNT_W'(1);
        end else begin
          phase_cnt = count_up(phase_cnt);
          if (phase_cnt >= cfg_period) begin
            rd.code = TO_START;
            frame_phase = PH_WAIT_NEXT;
            phase_cnt = '0;
          end
        end
      end
      PH_MEASURE: begin
        if (echo == cfg_level) begin
          phase_cnt = count_up(phase_cnt);
          if (phase_cnt >= cfg_period) begin
            rd.code = TO_END;
            frame_phase = PH_WAIT_NEXT;
            phase_cnt = '0;
          end
        end else begin
          // Echo ended: convert the width to cm and hold it.
          prod = ECHO_CM_NUM * longint'(phase_cnt);
          dist_hold = DIST_W'(prod / ECHO_CM_DEN);
          rd.fresh = 1'b1;
          frame_phase = PH_WAIT_NEXT;
          phase_cnt = '0;
        end
      end
      PH_WAIT_NEXT: begin
        if (frame_cnt >= cfg_period) begin
          rd.running = 1'b0;
          if (run) begin
            start = 1'b1;
          end else begin
            frame_phase = PH_IDLE;
            phase_cnt = '0;
            frame_cnt = '0;
          end
        end
      end
      default: begin
        if (run) begin
          start = 1'b1;
        end
      end
    endcase

    // A starting tick is frame tick 0 and the first trigger tick.
    if (start) begin
      frame_cnt = '0;
      rd.running = 1'b1;
      rd.trigger = 1'b1;
      phase_cnt = CNT_W'(1);
      if (phase_cnt >= CNT_W'(cfg_trig)) begin
        frame_phase = PH_WAIT_START;
        phase_cnt = '0;
      end else begin
        frame_phase = PH_TRIG;
      end
    end
    rd.distance = dist_hold;
  endtask

  // ---------------------------------------------------------------------------
  // Tick driver: pull from the backlog in bursts, with random gaps between.
  // ---------------------------------------------------------------------------
  echo_tick_t  tick_backlog[$];
  echo_tick_t  next_tick;
  int unsigned ticks_driven = 0;
  int unsigned ticks_taken  = 0;
  int unsigned burst_left   = 0;
  int unsigned gap_left     = 0;

  always @(negedge clk_i) begin
    // Only move on once the presented tick has been taken.
    if (rst_ni && ticks_taken == ticks_driven) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (tick_backlog.size() > 0) begin
        next_tick = tick_backlog.pop_front();
        in_valid_i <= 1'b1;
        echo_level_i <= next_tick.echo;
        run_i <= next_tick.run;
        ticks_driven <= ticks_driven + 1;
        if (burst_left <= 1) begin
          // Now and then a long burst with no idle ticks at all.
          if ($urandom_range(0, 5) == 0) begin
            burst_left <= $urandom_range(100, 200);
            gap_left <= 0;
          end else begin
            burst_left <= $urandom_range(1, 24);
            gap_left <= $urandom_range(0, 4);
          end
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result stall pattern: pick a random stall mode each time the 6-bit phase wraps.
  // ---------------------------------------------------------------------------
  stall_mode_e stall_mode = STALL_NONE;
  logic [5:0]  stall_phase = '0;

  always @(negedge clk_i) begin
    stall_phase <= stall_phase + 1'b1;
    if (stall_phase == '0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 3));
    end
    case (stall_mode)
      STALL_NONE:  out_stall_i <= 1'b0;
      STALL_LIGHT: out_stall_i <= ($urandom_range(0, 7) == 0);
      STALL_HEAVY: out_stall_i <= 1'($urandom_range(0, 1));
      default:     out_stall_i <= (stall_phase[3:0] >= 4'd11);
    endcase
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on each tick transfer, check on each result transfer.
  // ---------------------------------------------------------------------------
  ranger_reading_t readings_due[$];
  ranger_reading_t due_rd;
  ranger_reading_t fresh_rd;
  int unsigned     fail_cnt = 0;

  task automatic check_field(input string what, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
      fail_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        step_ranger(echo_level_i, run_i, fresh_rd);
        readings_due.push_back(fresh_rd);
        ticks_taken <= ticks_taken + 1;
      end
      if (out_valid_o && !out_stall_i) begin
        if (readings_due.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual %0d/%0d/%0d/%0d/%0d",
                   $time, trigger_out_o, distance_cm_o, new_distance_o, timeout_code_o,
                   running_o);
          fail_cnt++;
        end else begin
          due_rd = readings_due.pop_front();
          check_field("trigger_out", due_rd.trigger, trigger_out_o);
          check_field("distance_cm", due_rd.distance, distance_cm_o);
          check_field("new_distance", due_rd.fresh, new_distance_o);
          check_field("timeout_code", due_rd.code, timeout_code_o);
          check_field("running", due_rd.running, running_o);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: count cycles and give up at a generous limit.
  // ---------------------------------------------------------------------------
  int unsigned cycle_cnt = 0;

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  initial begin
    wait (cycle_cnt == TIMEOUT_CYCLES);
    $display("FAIL ultrasonic_echo_ranger");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------
  task automatic push_tick(input logic echo, input logic run);
    echo_tick_t t;
    t.echo = echo;
    t.run = run;
    tick_backlog.push_back(t);
  endtask

  // Hold until every queued tick is taken and every reading is back, then
  // let the pipeline settle.
  task automatic wait_quiet();
    while (tick_backlog.size() != 0 || in_valid_i || readings_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // APB write: setup cycle, access cycle, register lands on the access edge.
  task automatic write_reg(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) begin
      @(posedge clk_i);
    end
    case (addr)
      ADDR_ECHO_LEVEL: cfg_level = data[0];
      ADDR_PERIOD:     cfg_period = data[CNT_W-1:0];
      ADDR_TRIG_WIDTH: cfg_trig = data[TW_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_config(input logic level, input int unsigned period,
                            input int unsigned trig);
    wait_quiet();
    write_reg(ADDR_ECHO_LEVEL, DATA_W'(level));
    write_reg(ADDR_PERIOD, DATA_W'(period));
    write_reg(ADDR_TRIG_WIDTH, DATA_W'(trig));
  endtask

  // Mostly well-formed echoes (quiet gap, then an active pulse) with random
  // lengths, mixed with short bursts of noise on both echo and run.
  task automatic queue_pulses(input int unsigned n, input logic level,
                              input int unsigned gap_max, input int unsigned width_max);
    int unsigned k;
    int unsigned gap;
    int unsigned width;
    logic        run;
    k = 0;
    while (k < n) begin
      run = ($urandom_range(0, 7) != 0);
      if ($urandom_range(0, 5) == 0) begin
        width = $urandom_range(1, 10);
        repeat (width) push_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        k += width;
      end else begin
        gap = $urandom_range(0, gap_max);
        width = $urandom_range(1, width_max);
        // Trim the last pulse so the batch stays near its tick budget.
        if (gap + width > n - k) begin
          gap = (n - k) / 2;
          width = n - k - gap;
        end
        repeat (gap) push_tick(~level, run);
        repeat (width) push_tick(level, run);
        k += gap + width;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned p;
    int unsigned t;
    logic        lvl;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Zero period and zero trigger width: start timeout, end timeout,
    // a one-tick echo that gives zero cm, restart on the spot, then a stop request.
    set_config(1'b1, 0, 0);
    push_tick(1'b0, 1'b0);
    push_tick(1'b0, 1'b1);
    push_tick(1'b0, 1'b1);
    push_tick(1'b1, 1'b1);
    push_tick(1'b1, 1'b1);
    push_tick(1'b1, 1'b1);
    push_tick(1'b0, 1'b1);
    push_tick(1'b1, 1'b0);
    push_tick(1'b0, 1'b0);
    push_tick(1'b0, 1'b0);

    // Active-low echo, short frame: measure a pulse, then restart a frame.
    set_config(1'b0, 6, 2);
    push_tick(1'b1, 1'b1);
    push_tick(1'b1, 1'b1);
    push_tick(1'b1, 1'b1);
    push_tick(1'b0, 1'b1);
    push_tick(1'b0, 1'b1);
    push_tick(1'b0, 1'b1);
    push_tick(1'b1, 1'b1);
    push_tick(1'b1, 1'b1);

    // Shorten the period in the middle of the trigger phase, then stop.
    wait_quiet();
    write_reg(ADDR_PERIOD, DATA_W'(3));
    push_tick(1'b1, 1'b1);
    push_tick(1'b1, 1'b1);
    push_tick(1'b1, 1'b1);
    push_tick(1'b1, 1'b1);
    push_tick(1'b0, 1'b0);
    push_tick(1'b1, 1'b0);

    // Period 1000 with the widest trigger: one clean long echo,
    // then random pulses.
    set_config(1'b1, 1000, 255);
    repeat (260) push_tick(1'b0, 1'b1);
    repeat (300) push_tick(1'b1, 1'b1);
    repeat (40) push_tick(1'b0, 1'b1);
    queue_pulses(150, 1'b1, 300, 600);

    // Long period of 1000000, trigger width 10, active-low echo.
    set_config(1'b0, 1000000, 10);
    queue_pulses(60, 1'b0, 20, 30);

    // Random settings, mostly short frames so that many complete.
    repeat (4) begin
      lvl = 1'($urandom_range(0, 1));
      p = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 4) : $urandom_range(5, 120);
      t = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 24);
      set_config(lvl, p, t);
      queue_pulses($urandom_range(50, 70), lvl, t + p / 2 + 2, p + 3);
    end

    wait_quiet();
    if (fail_cnt == 0) begin
      $display("PASS ultrasonic_echo_ranger");
    end else begin
      $display("FAIL ultrasonic_echo_ranger");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/uer_pkg.sv
hw/rtl/ultrasonic_echo_ranger.sv
hw/rtl/uer_checker.sv
tb/tb_ultrasonic_echo_ranger.sv
